@@ src/bpbs_pkg.sv @@
// ----------------------------------------------------------------------------
// bpbs_pkg
// Shared types and constants for the ballistic particle bounce step: register
// map, configuration struct and register reset values.
// ----------------------------------------------------------------------------
package bpbs_pkg;

  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_NOMINAL_DT   = 2'd0,
    REG_BOUNCE_GAIN  = 2'd1,
    REG_GROUND_LEVEL = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] nominal_dt;
    logic        [15:0] bounce_gain;
    logic signed [31:0] ground_level;
  } cfg_t;

  localparam logic        [15:0] NOMINAL_DT_RST   = 16'd655;
  localparam logic        [15:0] BOUNCE_GAIN_RST  = 16'd26214;
  localparam logic signed [31:0] GROUND_LEVEL_RST = -32'sd262144;

endpackage

@@ src/ballistic_particle_bounce_step.sv @@
// ----------------------------------------------------------------------------
// ballistic_particle_bounce_step
// Seven-stage pipeline that moves one particle per item under gravity and
// bounces it off the ground plane.
// ----------------------------------------------------------------------------
// The block accepts one particle in every cycle unless the output stalls;
// the rate is set by the seven-stage datapath (step select, velocity and
// gravity products, rounding, gravity drop product, position sums, ground
// test with gain product, rounding and saturation), which holds up to seven
// particles at once and fills bubbles while the output stalls. Values carry
// FRAC_BITS fraction bits (8 to 24); configuration must be written over the
// APB port only while no particle is in flight; the block does not check it.
module ballistic_particle_bounce_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpbs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          pos_z,
  input  logic signed [31:0]          vel_x,
  input  logic signed [31:0]          vel_y,
  input  logic signed [31:0]          vel_z,
  input  logic signed [15:0]          jitter_x,
  input  logic signed [15:0]          jitter_z,
  input  logic        [30:0]          time_left,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          new_pos_x,
  output logic signed [31:0]          new_pos_y,
  output logic signed [31:0]          new_pos_z,
  output logic signed [31:0]          new_vel_x,
  output logic signed [31:0]          new_vel_y,
  output logic signed [31:0]          new_vel_z,
  output logic                        bounced
);

  localparam int DT_W  = FRAC_BITS;
  localparam int G_W   = FRAC_BITS + 4;
  localparam int GP_W  = G_W + DT_W;
  localparam int P_W   = 32 + DT_W + 1;
  localparam int SUM_W = 36;
  localparam int VY_W  = 33;
  localparam int NV_W  = VY_W + 1;
  localparam int FP_W  = NV_W + 17;

  localparam logic [G_W-1:0] G = G_W'(((64'd98 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [P_W-1:0]  HALF_P  = P_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic        [GP_W-1:0] HALF_GP = GP_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic        [GP_W-1:0] HALF_GG = GP_W'(64'd1 << FRAC_BITS);
  localparam logic signed [FP_W-1:0] HALF_F  = FP_W'(64'd1 << 14);
  localparam logic signed [FP_W-1:0] SAT_HI  = FP_W'(64'd2147483647);
  localparam logic signed [FP_W-1:0] SAT_LO  = ~SAT_HI;

  function automatic logic [31:0] sat32(input logic signed [FP_W-1:0] v);
    logic [31:0] r;
    if (v > SAT_HI)
      r = SAT_HI[31:0];
    else if (v < SAT_LO)
      r = SAT_LO[31:0];
    else
      r = v[31:0];
    return r;
  endfunction

  bpbs_pkg::cfg_t cfg;

  bpbs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // stage control: a stage advances when it is empty or the next one advances
  logic [7:1] v;
  logic [7:1] en;

  always_comb begin
    en[7] = !v[7] || out_ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: step select
  logic [DT_W-1:0] dtn;
  logic [DT_W-1:0] dt_in;

  if (FRAC_BITS >= 16) begin : g_dt_up
    assign dtn = DT_W'(cfg.nominal_dt) << (FRAC_BITS - 16);
  end else begin : g_dt_dn
    assign dtn = DT_W'(cfg.nominal_dt >> (16 - FRAC_BITS));
  end

  assign dt_in = (31'(dtn) < time_left) ? dtn : time_left[DT_W-1:0];

  logic signed [31:0] s1_px, s1_py, s1_pz, s1_vx, s1_vy, s1_vz;
  logic signed [15:0] s1_jx, s1_jz;
  logic [DT_W-1:0]    s1_dt;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_px <= pos_x;
      s1_py <= pos_y;
      s1_pz <= pos_z;
      s1_vx <= vel_x;
      s1_vy <= vel_y;
      s1_vz <= vel_z;
      s1_jx <= jitter_x;
      s1_jz <= jitter_z;
      s1_dt <= dt_in;
    end
  end

  // stage 2: velocity and gravity products
  logic signed [P_W-1:0] s2_mx, s2_my, s2_mz;
  logic [GP_W-1:0]       s2_gp;
  logic signed [31:0]    s2_px, s2_py, s2_pz, s2_vx, s2_vy, s2_vz;
  logic signed [15:0]    s2_jx, s2_jz;
  logic [DT_W-1:0]       s2_dt;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_mx <= P_W'(s1_vx) * P_W'($signed({1'b0, s1_dt}));
      s2_my <= P_W'(s1_vy) * P_W'($signed({1'b0, s1_dt}));
      s2_mz <= P_W'(s1_vz) * P_W'($signed({1'b0, s1_dt}));
      s2_gp <= GP_W'(G) * GP_W'(s1_dt);
      s2_px <= s1_px;
      s2_py <= s1_py;
      s2_pz <= s1_pz;
      s2_vx <= s1_vx;
      s2_vy <= s1_vy;
      s2_vz <= s1_vz;
      s2_jx <= s1_jx;
      s2_jz <= s1_jz;
      s2_dt <= s1_dt;
    end
  end

  // stage 3: round products
  logic signed [P_W-1:0] rx, ry, rz;
  logic [GP_W-1:0]       gdt_full;

  assign rx       = (s2_mx + HALF_P) >>> FRAC_BITS;
  assign ry       = (s2_my + HALF_P) >>> FRAC_BITS;
  assign rz       = (s2_mz + HALF_P) >>> FRAC_BITS;
  assign gdt_full = (s2_gp + HALF_GP) >> FRAC_BITS;

  logic signed [SUM_W-1:0] s3_dx, s3_dy, s3_dz;
  logic [G_W-1:0]          s3_gdt;
  logic signed [31:0]      s3_px, s3_py, s3_pz, s3_vx, s3_vy, s3_vz;
  logic signed [15:0]      s3_jx, s3_jz;
  logic [DT_W-1:0]         s3_dt;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_dx  <= rx[SUM_W-1:0];
      s3_dy  <= ry[SUM_W-1:0];
      s3_dz  <= rz[SUM_W-1:0];
      s3_gdt <= gdt_full[G_W-1:0];
      s3_px  <= s2_px;
      s3_py  <= s2_py;
      s3_pz  <= s2_pz;
      s3_vx  <= s2_vx;
      s3_vy  <= s2_vy;
      s3_vz  <= s2_vz;
      s3_jx  <= s2_jx;
      s3_jz  <= s2_jz;
      s3_dt  <= s2_dt;
    end
  end

  // stage 4: gravity drop product, vertical velocity
  logic [GP_W-1:0]         s4_gg;
  logic signed [VY_W-1:0]  s4_vyn;
  logic signed [SUM_W-1:0] s4_dx, s4_dy, s4_dz;
  logic signed [31:0]      s4_px, s4_py, s4_pz, s4_vx, s4_vz;
  logic signed [15:0]      s4_jx, s4_jz;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_gg  <= GP_W'(s3_gdt) * GP_W'(s3_dt);
      s4_vyn <= VY_W'(s3_vy) - VY_W'($signed({1'b0, s3_gdt}));
      s4_dx  <= s3_dx;
      s4_dy  <= s3_dy;
      s4_dz  <= s3_dz;
      s4_px  <= s3_px;
      s4_py  <= s3_py;
      s4_pz  <= s3_pz;
      s4_vx  <= s3_vx;
      s4_vz  <= s3_vz;
      s4_jx  <= s3_jx;
      s4_jz  <= s3_jz;
    end
  end

  // stage 5: position sums
  logic [GP_W-1:0]         drop_full;
  logic signed [SUM_W-1:0] drop;

  assign drop_full = (s4_gg + HALF_GG) >> (FRAC_BITS + 1);
  assign drop      = $signed(SUM_W'(drop_full));

  logic signed [SUM_W-1:0] s5_px, s5_py, s5_pz;
  logic signed [VY_W-1:0]  s5_vyn;
  logic signed [31:0]      s5_vx, s5_vz;
  logic signed [15:0]      s5_jx, s5_jz;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_px  <= SUM_W'(s4_px) + s4_dx;
      s5_py  <= SUM_W'(s4_py) + s4_dy - drop;
      s5_pz  <= SUM_W'(s4_pz) + s4_dz;
      s5_vyn <= s4_vyn;
      s5_vx  <= s4_vx;
      s5_vz  <= s4_vz;
      s5_jx  <= s4_jx;
      s5_jz  <= s4_jz;
    end
  end

  // stage 6: ground test, gain product
  logic signed [SUM_W-1:0] gl;
  logic signed [NV_W-1:0]  nvy;
  logic                    hit;

  assign gl  = SUM_W'(cfg.ground_level);
  assign hit = s5_py <= gl;
  assign nvy = -(NV_W'(s5_vyn));

  logic signed [FP_W-1:0]  s6_fp;
  logic signed [SUM_W-1:0] s6_px, s6_py, s6_pz;
  logic signed [VY_W-1:0]  s6_vyn;
  logic signed [31:0]      s6_vx, s6_vz;
  logic                    s6_hit;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_fp  <= FP_W'(nvy) * FP_W'($signed({1'b0, cfg.bounce_gain}));
      s6_px  <= hit ? s5_px + SUM_W'(s5_jx) : s5_px;
      s6_py  <= hit ? gl : s5_py;
      s6_pz  <= hit ? s5_pz + SUM_W'(s5_jz) : s5_pz;
      s6_vyn <= s5_vyn;
      s6_vx  <= s5_vx;
      s6_vz  <= s5_vz;
      s6_hit <= hit;
    end
  end

  // stage 7: round, select, saturate
  logic signed [FP_W-1:0] vr;
  logic signed [FP_W-1:0] vy_fin;

  assign vr     = (s6_fp + HALF_F) >>> 15;
  assign vy_fin = s6_hit ? vr : FP_W'(s6_vyn);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      new_pos_x <= sat32(FP_W'(s6_px));
      new_pos_y <= sat32(FP_W'(s6_py));
      new_pos_z <= sat32(FP_W'(s6_pz));
      new_vel_x <= s6_vx;
      new_vel_y <= sat32(vy_fin);
      new_vel_z <= s6_vz;
      bounced   <= s6_hit;
    end
  end

endmodule

@@ src/bpbs_cfg.sv @@
// ----------------------------------------------------------------------------
// bpbs_cfg
// APB-style configuration registers: nominal step, bounce gain and
// ground level. Writes beyond the register map are dropped.
// ----------------------------------------------------------------------------
module bpbs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpbs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output bpbs_pkg::cfg_t              cfg
);

  bpbs_pkg::reg_idx_t idx;
  logic               wr;

  assign idx = bpbs_pkg::reg_idx_t'(paddr[3:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nominal_dt   <= bpbs_pkg::NOMINAL_DT_RST;
      cfg.bounce_gain  <= bpbs_pkg::BOUNCE_GAIN_RST;
      cfg.ground_level <= bpbs_pkg::GROUND_LEVEL_RST;
    end else if (wr) begin
      case (idx)
        bpbs_pkg::REG_NOMINAL_DT:   cfg.nominal_dt   <= pwdata[15:0];
        bpbs_pkg::REG_BOUNCE_GAIN:  cfg.bounce_gain  <= pwdata[15:0];
        bpbs_pkg::REG_GROUND_LEVEL: cfg.ground_level <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bpbs_pkg::REG_NOMINAL_DT:   prdata = {16'd0, cfg.nominal_dt};
      bpbs_pkg::REG_BOUNCE_GAIN:  prdata = {16'd0, cfg.bounce_gain};
      bpbs_pkg::REG_GROUND_LEVEL: prdata = cfg.ground_level;
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

@@ bench/tb_ballistic_particle_bounce_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ballistic_particle_bounce_step
// Self-checking bench for the particle bounce step pipeline. A driver feeds
// particles from a queue; each accepted item is run through a local fixed-point
// predictor and the expected step is compared field by field with the block's
// output. Configuration is rewritten over APB between phases, with varied
// idling on both channels, a long output stall and drain pauses.
// ----------------------------------------------------------------------------
module tb_ballistic_particle_bounce_step;

  localparam int FRAC         = 16;
  localparam int REG_UNUSED   = 3;
  localparam int LONG_STALL   = 300;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [31:0] S_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] S_MIN  = 32'h8000_0000;
  localparam logic [15:0] J_MAX  = 16'h7fff;
  localparam logic [15:0] J_MIN  = 16'h8000;
  localparam logic [30:0] TL_MAX = 31'h7fff_ffff;

  typedef struct packed {
    logic [31:0] px, py, pz, vx, vy, vz;
    logic [15:0] jx, jz;
    logic [30:0] tl;
  } particle_t;

  typedef struct packed {
    logic [31:0] px, py, pz, vx, vy, vz;
    logic        hit;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [bpbs_pkg::ADDR_W-1:0] paddr   = '0;
  logic [31:0]                 pwdata  = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  particle_t   drv       = '0;

  logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
  logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;
  logic               bounced;

  particle_t      pending_particles[$];
  step_result_t   expected_steps[$];
  step_result_t   want_step;
  bpbs_pkg::cfg_t model_cfg = {bpbs_pkg::NOMINAL_DT_RST, bpbs_pkg::BOUNCE_GAIN_RST,
                               bpbs_pkg::GROUND_LEVEL_RST};

  logic in_taken  = 1'b0;
  logic out_hold  = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   errors = 0;
  event stall_kick;

  ballistic_particle_bounce_step #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(drv.px), .pos_y(drv.py), .pos_z(drv.pz),
    .vel_x(drv.vx), .vel_y(drv.vy), .vel_z(drv.vz),
    .jitter_x(drv.jx), .jitter_z(drv.jz), .time_left(drv.tl),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_pos_x(new_pos_x), .new_pos_y(new_pos_y), .new_pos_z(new_pos_z),
    .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z),
    .bounced(bounced)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > longint'(32'sh7fff_ffff)) return S_MAX;
    if (v < -longint'(64'h8000_0000)) return S_MIN;
    return v[31:0];
  endfunction

  function automatic step_result_t advance_particle(particle_t p, bpbs_pkg::cfg_t c);
    longint gconst, dtn, dt, gdt, x, y, z, vy, floor_y;
    step_result_t r;
    gconst = ((longint'(98) <<< FRAC) + 5) / 10;
    if (FRAC >= 16) dtn = longint'(c.nominal_dt) <<< (FRAC - 16);
    else dtn = longint'(c.nominal_dt) >>> (16 - FRAC);
    dt = (dtn < longint'(p.tl)) ? dtn : longint'(p.tl);
    gdt = round_shift(gconst * dt, FRAC);
    x = longint'($signed(p.px)) + round_shift(longint'($signed(p.vx)) * dt, FRAC);
    z = longint'($signed(p.pz)) + round_shift(longint'($signed(p.vz)) * dt, FRAC);
    y = longint'($signed(p.py)) + round_shift(longint'($signed(p.vy)) * dt, FRAC)
        - round_shift(gdt * dt, FRAC + 1);
    vy = longint'($signed(p.vy)) - gdt;
    floor_y = longint'($signed(c.ground_level));
    r.hit = (y <= floor_y);
    if (r.hit) begin
      y  = floor_y;
      vy = round_shift(-vy * longint'(c.bounce_gain), 15);
      x  = x + longint'($signed(p.jx));
      z  = z + longint'($signed(p.jz));
    end
    r.px = clamp32(x);
    r.py = clamp32(y);
    r.pz = clamp32(z);
    r.vx = p.vx;
    r.vy = clamp32(vy);
    r.vz = p.vz;
    return r;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(2))
      0: return S_MAX;
      1: return S_MIN;
      default: return $urandom;
    endcase
  endfunction

  task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ERROR %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  // drive items and the output ready at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_particles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv      <= pending_particles.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hold the output off for a long stretch on request
  always begin
    @(stall_kick);
    out_hold <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    out_hold <= 1'b0;
  end

  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready)
      expected_steps.push_back(advance_particle(drv, model_cfg));
    if (!rst && out_valid && out_ready) begin
      if (expected_steps.size() == 0) begin
        errors++;
        $display("%0t ERROR unexpected item: expected none, actual pos %h %h %h",
                 $time, new_pos_x, new_pos_y, new_pos_z);
      end else begin
        want_step = expected_steps.pop_front();
        compare_field("new_pos_x", want_step.px, new_pos_x);
        compare_field("new_pos_y", want_step.py, new_pos_y);
        compare_field("new_pos_z", want_step.pz, new_pos_z);
        compare_field("new_vel_x", want_step.vx, new_vel_x);
        compare_field("new_vel_y", want_step.vy, new_vel_y);
        compare_field("new_vel_z", want_step.vz, new_vel_z);
        compare_field("bounced", {31'd0, want_step.hit}, {31'd0, bounced});
      end
    end
  end

  task automatic write_reg(int idx, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bpbs_pkg::ADDR_W'(idx * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      bpbs_pkg::REG_NOMINAL_DT:   model_cfg.nominal_dt   = data[15:0];
      bpbs_pkg::REG_BOUNCE_GAIN:  model_cfg.bounce_gain  = data[15:0];
      bpbs_pkg::REG_GROUND_LEVEL: model_cfg.ground_level = data;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_particles.size() != 0 || in_valid || expected_steps.size() != 0)
      @(posedge clk);
  endtask

  task automatic add_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                              logic [15:0] jx, logic [15:0] jz, logic [30:0] tl);
    pending_particles.push_back({px, py, pz, vx, vy, vz, jx, jz, tl});
  endtask

  task automatic run_phase(int count, int sidle, int rstall, bit long_stall);
    particle_t p;
    int        mode;
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    if (long_stall) -> stall_kick;
    // pause halfway until the pipeline has drained
    for (int half = 0; half < 2; half++) begin
      repeat (count / 2) begin
        p.px = $urandom;
        p.py = $urandom;
        p.pz = $urandom;
        p.vx = $urandom;
        p.vy = $urandom;
        p.vz = $urandom;
        p.jx = 16'($urandom);
        p.jz = 16'($urandom);
        p.tl = 31'($urandom);
        mode = $urandom_range(9);
        if (mode >= 3) begin
          // typical flight close to the ground plane
          p.px = $urandom_range(0, 1 << 24) - (1 << 23);
          p.pz = $urandom_range(0, 1 << 24) - (1 << 23);
          p.py = model_cfg.ground_level + ($urandom_range(0, 3 << 16) - (1 << 16));
          p.vx = $urandom_range(0, 1 << 21) - (1 << 20);
          p.vy = $urandom_range(0, 1 << 21) - (1 << 20);
          p.vz = $urandom_range(0, 1 << 21) - (1 << 20);
          p.tl = 31'(($urandom_range(3) == 0) ? $urandom_range(0, 700)
                                              : $urandom_range(0, 1 << 20));
        end else if (mode == 0) begin
          p.px = pick_extreme();
          p.py = pick_extreme();
          p.pz = pick_extreme();
          p.vx = pick_extreme();
          p.vy = pick_extreme();
          p.vz = pick_extreme();
        end
        pending_particles.push_back(p);
      end
      wait_idle();
    end
  endtask

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [31:0] g0;
    g0 = bpbs_pkg::GROUND_LEVEL_RST;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed items under reset configuration
    add_particle('0, '0, '0, '0, '0, '0, '0, '0, '0);
    add_particle('0, g0, '0, '0, '0, '0, J_MAX, J_MIN, '0);
    add_particle('0, g0 + 1, '0, '0, '0, '0, J_MAX, J_MIN, '0);
    add_particle('0, g0 + 1, '0, '0, '0, '0, '0, '0, 31'd1);
    add_particle(32'd100, g0 - 32'd5000, 32'd200, '0, -32'sd327680, '0, J_MAX, J_MAX, '0);
    add_particle(32'd1 << 16, 32'd10 << 16, 32'd3 << 16, 32'd1 << 16, 32'd2 << 16,
                 -32'sd65536, '0, '0, TL_MAX);
    add_particle(S_MAX, '0, S_MAX, S_MAX, '0, S_MAX, '0, '0, TL_MAX);
    add_particle(S_MIN, '0, S_MIN, S_MIN, '0, S_MIN, '0, '0, TL_MAX);
    add_particle(S_MAX, S_MIN, S_MIN, '0, '0, '0, J_MAX, J_MIN, 31'd655);
    add_particle(S_MIN, S_MIN, S_MAX, '0, '0, '0, J_MIN, J_MAX, 31'd655);
    add_particle('0, g0, '0, '0, S_MIN, '0, '0, '0, TL_MAX);
    add_particle('0, g0, '0, '0, S_MAX, '0, '0, '0, TL_MAX);
    add_particle('0, S_MAX, '0, '0, S_MAX, '0, '0, '0, TL_MAX);
    add_particle('0, S_MAX, '0, '0, S_MIN, '0, '0, '0, TL_MAX);
    add_particle(32'd5, g0 - 32'd1, 32'd7, '0, '0, '0, 16'hffff, 16'h0001, 31'd1);
    add_particle(32'd1 << 16, g0 + (32'd1 << 16), '0, 32'd3 << 16, 32'd1 << 16, '0,
                 '0, '0, 31'd654);
    add_particle(32'd1 << 16, g0 + (32'd1 << 16), '0, 32'd3 << 16, 32'd1 << 16, '0,
                 '0, '0, 31'd656);
    add_particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 16'($urandom), 16'($urandom), 31'($urandom));
    wait_idle();
    run_phase(100, 0, 0, 1'b0);

    write_reg(bpbs_pkg::REG_NOMINAL_DT, 32'd65535);
    write_reg(bpbs_pkg::REG_BOUNCE_GAIN, 32'd65535);
    write_reg(bpbs_pkg::REG_GROUND_LEVEL, 32'd0);
    run_phase(130, 60, 0, 1'b0);

    write_reg(bpbs_pkg::REG_NOMINAL_DT, 32'd0);
    write_reg(bpbs_pkg::REG_BOUNCE_GAIN, 32'd0);
    write_reg(bpbs_pkg::REG_GROUND_LEVEL, S_MAX);
    write_reg(REG_UNUSED, $urandom);
    run_phase(130, 0, 60, 1'b0);

    write_reg(bpbs_pkg::REG_NOMINAL_DT, 32'd1000);
    write_reg(bpbs_pkg::REG_BOUNCE_GAIN, 32'd32768);
    write_reg(bpbs_pkg::REG_GROUND_LEVEL, S_MIN);
    run_phase(130, 25, 25, 1'b1);

    write_reg(bpbs_pkg::REG_NOMINAL_DT, $urandom_range(0, 65535));
    write_reg(bpbs_pkg::REG_BOUNCE_GAIN, $urandom_range(0, 65535));
    write_reg(bpbs_pkg::REG_GROUND_LEVEL, $urandom);
    run_phase(130, 25, 25, 1'b0);

    write_reg(bpbs_pkg::REG_GROUND_LEVEL, g0);
    write_reg(bpbs_pkg::REG_NOMINAL_DT, $urandom_range(0, 65535));
    write_reg(bpbs_pkg::REG_BOUNCE_GAIN, $urandom_range(0, 32768));
    run_phase(130, 0, 0, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
